FILE: hw/rtl/rtsq_pkg.sv
// Shared types and constants for the RGB to CMYK step quantizer.
package rtsq_pkg;

  // Field widths.
  localparam int COLOR_W   = 8;
  localparam int STEPS_W   = 8;
  localparam int LENGTH_W  = 16;
  localparam int LEN_W     = 24;

  // Divider geometry: one quotient bit per cell, four lanes side by side.
  localparam int NUM_LANES = 4;
  localparam int NUM_CELLS = STEPS_W;
  localparam int REM_W     = 9;
  localparam int DIV_W     = 9;
  localparam int PROD_W    = 2 * COLOR_W;
  localparam int DIVIDEND_W = PROD_W + 1;

  // Lane order inside the divider chain.
  localparam int LANE_CYAN    = 0;
  localparam int LANE_MAGENTA = 1;
  localparam int LANE_YELLOW  = 2;
  localparam int LANE_KEY     = 3;

  localparam logic [COLOR_W-1:0] FULL_SCALE = 8'd255;
  // Half of full scale, rounded down; used to round the key quotient.
  localparam logic [COLOR_W-1:0] HALF_SCALE = 8'd127;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH = 2'd1;
  localparam logic [STEPS_W-1:0]  STEP_COUNT_RESET  = 8'd255;
  localparam logic [LENGTH_W-1:0] STEP_LENGTH_RESET = 16'd256;

  // One input item: an RGB pixel.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  // One result item: quantized CMYK strengths and their lengths.
  typedef struct packed {
    logic [STEPS_W-1:0] cyan_steps;
    logic [STEPS_W-1:0] magenta_steps;
    logic [STEPS_W-1:0] yellow_steps;
    logic [STEPS_W-1:0] key_steps;
    logic [LEN_W-1:0]   cyan_len;
    logic [LEN_W-1:0]   magenta_len;
    logic [LEN_W-1:0]   yellow_len;
    logic [LEN_W-1:0]   key_len;
  } result_t;

  // Restoring divider lane: partial remainder, dividend bits still to be
  // shifted in (which turn into quotient bits from the bottom), and divisor.
  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [STEPS_W-1:0] low;
    logic [DIV_W-1:0]   div;
  } lane_t;

endpackage

FILE: hw/rtl/rtsq_prep.sv
// Front stage: finds the brightest channel, forms the color dividends and resolves key.
module rtsq_prep (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  rtsq_pkg::pixel_t                        pix,
  input  logic [rtsq_pkg::STEPS_W-1:0]            step_count,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] out_lanes
);

  logic [rtsq_pkg::COLOR_W-1:0]    mx;
  logic [rtsq_pkg::COLOR_W-1:0]    div_base;
  logic [rtsq_pkg::COLOR_W-1:0]    col [rtsq_pkg::NUM_LANES-1];
  logic [rtsq_pkg::COLOR_W-1:0]    num [rtsq_pkg::NUM_LANES];
  logic [rtsq_pkg::COLOR_W-1:0]    den [rtsq_pkg::NUM_LANES];
  logic [rtsq_pkg::PROD_W-1:0]     prod [rtsq_pkg::NUM_LANES];
  logic [rtsq_pkg::DIVIDEND_W-1:0] dividend [rtsq_pkg::NUM_LANES];
  logic [rtsq_pkg::PROD_W-1:0]     key_sum;
  logic [rtsq_pkg::PROD_W:0]       key_acc;
  rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] lanes_next;

  assign in_ready = !out_valid || out_ready;

  // Largest of the three colors. A black pixel divides by one instead of
  // zero; its numerators are all zero, so the color steps come out zero.
  always_comb begin
    col[rtsq_pkg::LANE_CYAN]    = pix.red;
    col[rtsq_pkg::LANE_MAGENTA] = pix.green;
    col[rtsq_pkg::LANE_YELLOW]  = pix.blue;
    mx = pix.red;
    if (pix.green > mx) begin
      mx = pix.green;
    end
    if (pix.blue > mx) begin
      mx = pix.blue;
    end
    div_base = (mx == '0) ? rtsq_pkg::COLOR_W'(1) : mx;
  end

  // Rounded quotient round(n*s/d) is floor((2*n*s + d) / (2*d)). The top
  // bits of the dividend seed the remainder; the low bits enter one a cell.
  always_comb begin
    for (int i = 0; i < rtsq_pkg::NUM_LANES; i++) begin
      if (i == rtsq_pkg::LANE_KEY) begin
        num[i] = rtsq_pkg::FULL_SCALE - mx;
        den[i] = rtsq_pkg::COLOR_W'(1);
      end else begin
        num[i] = mx - col[i];
        den[i] = div_base;
      end
      prod[i]     = num[i] * step_count;
      dividend[i] = {prod[i], 1'b0} + rtsq_pkg::DIVIDEND_W'(den[i]);
      lanes_next[i].rem = dividend[i][rtsq_pkg::DIVIDEND_W-1:rtsq_pkg::STEPS_W];
      lanes_next[i].low = dividend[i][rtsq_pkg::STEPS_W-1:0];
      lanes_next[i].div = {den[i], 1'b0};
    end
    // The key divisor is the constant 255: round(n*s/255) is
    // floor((n*s + 127) / 255), and below 2^16 floor(y/255) equals
    // (y + (y >> 8) + 1) >> 8. The finished quotient rides the chain with
    // a divisor of one, which each cell passes through unchanged.
    key_sum = prod[rtsq_pkg::LANE_KEY] + rtsq_pkg::PROD_W'(rtsq_pkg::HALF_SCALE);
    key_acc = {1'b0, key_sum} +
              (rtsq_pkg::PROD_W+1)'(key_sum[rtsq_pkg::PROD_W-1:rtsq_pkg::COLOR_W]) +
              (rtsq_pkg::PROD_W+1)'(1);
    lanes_next[rtsq_pkg::LANE_KEY].rem = '0;
    lanes_next[rtsq_pkg::LANE_KEY].low = key_acc[rtsq_pkg::PROD_W-1:rtsq_pkg::COLOR_W];
    lanes_next[rtsq_pkg::LANE_KEY].div = rtsq_pkg::DIV_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_lanes <= lanes_next;
    end
  end

endmodule

FILE: hw/rtl/rtsq_div_cell.sv
// One restoring-division cell: produces one quotient bit on every lane.
module rtsq_div_cell (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] in_lanes,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] out_lanes
);

  rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] lanes_next;

  assign in_ready = !out_valid || out_ready;

  // Shift the next dividend bit into the remainder, subtract the divisor
  // when it fits, and shift the quotient bit into the bottom of the word.
  always_comb begin
    logic [rtsq_pkg::REM_W:0] trial;
    logic [rtsq_pkg::REM_W:0] diff;
    logic                     fits;
    for (int i = 0; i < rtsq_pkg::NUM_LANES; i++) begin
      trial = {in_lanes[i].rem, in_lanes[i].low[rtsq_pkg::STEPS_W-1]};
      diff  = trial - {1'b0, in_lanes[i].div};
      fits  = (trial >= {1'b0, in_lanes[i].div});
      lanes_next[i].rem = fits ? diff[rtsq_pkg::REM_W-1:0] : trial[rtsq_pkg::REM_W-1:0];
      lanes_next[i].low = {in_lanes[i].low[rtsq_pkg::STEPS_W-2:0], fits};
      lanes_next[i].div = in_lanes[i].div;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_lanes <= lanes_next;
    end
  end

endmodule

FILE: hw/rtl/rtsq_scale.sv
// Output stage: scales each step count by the step length and holds the item.
module rtsq_scale (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] in_lanes,
  input  logic [rtsq_pkg::LENGTH_W-1:0]             step_length,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output rtsq_pkg::result_t                         res
);

  logic [rtsq_pkg::LEN_W-1:0] len [rtsq_pkg::NUM_LANES];
  rtsq_pkg::result_t          res_next;

  assign in_ready = !out_valid || out_ready;

  // After the last cell the low word of each lane is its quotient.
  always_comb begin
    for (int i = 0; i < rtsq_pkg::NUM_LANES; i++) begin
      len[i] = in_lanes[i].low * step_length;
    end
    res_next.cyan_steps    = in_lanes[rtsq_pkg::LANE_CYAN].low;
    res_next.magenta_steps = in_lanes[rtsq_pkg::LANE_MAGENTA].low;
    res_next.yellow_steps  = in_lanes[rtsq_pkg::LANE_YELLOW].low;
    res_next.key_steps     = in_lanes[rtsq_pkg::LANE_KEY].low;
    res_next.cyan_len      = len[rtsq_pkg::LANE_CYAN];
    res_next.magenta_len   = len[rtsq_pkg::LANE_MAGENTA];
    res_next.yellow_len    = len[rtsq_pkg::LANE_YELLOW];
    res_next.key_len       = len[rtsq_pkg::LANE_KEY];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/rgb_to_cmyk_step_quantizer.sv
// Top level of the RGB to CMYK step quantizer.
//
// Takes one RGB pixel per clock, unless the result side stalls, and returns
// its cyan, magenta, yellow and key step counts, each rounded half up, with
// their lengths in Q16.8 mm. A pixel passes a front stage that finds the
// brightest channel, forms the color dividends and resolves the key count,
// then a chain of eight divider cells that each resolve one quotient bit for
// the three color channels, then an output register that applies the step
// length. Every stage is registered, so a new pixel can be taken while
// earlier ones are still in flight, as long as the result side does not stall.
// Stalls on the result side only back up as far as the pipeline is full,
// so bubbles are squeezed out. Configuration writes are always taken and
// should be made with no pixel in flight.
module rgb_to_cmyk_step_quantizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  rtsq_pkg::pixel_t                    pix,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rtsq_pkg::result_t                   res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rtsq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rtsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [rtsq_pkg::STEPS_W-1:0]  step_count;
  logic [rtsq_pkg::LENGTH_W-1:0] step_length;

  logic                                      stage_valid [rtsq_pkg::NUM_CELLS+1];
  logic                                      stage_ready [rtsq_pkg::NUM_CELLS+1];
  rtsq_pkg::lane_t [rtsq_pkg::NUM_LANES-1:0] stage_lanes [rtsq_pkg::NUM_CELLS+1];

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= rtsq_pkg::STEP_COUNT_RESET;
      step_length <= rtsq_pkg::STEP_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtsq_pkg::CFG_STEP_COUNT: begin
          step_count <= cfg_data[rtsq_pkg::STEPS_W-1:0];
        end
        rtsq_pkg::CFG_STEP_LENGTH: begin
          step_length <= cfg_data[rtsq_pkg::LENGTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front stage.
  rtsq_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix_valid),
    .in_ready   (pix_ready),
    .pix        (pix),
    .step_count (step_count),
    .out_valid  (stage_valid[0]),
    .out_ready  (stage_ready[0]),
    .out_lanes  (stage_lanes[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar k = 0; k < rtsq_pkg::NUM_CELLS; k++) begin : g_cell
    rtsq_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_lanes  (stage_lanes[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_lanes (stage_lanes[k+1])
    );
  end

  // Output register.
  rtsq_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage_valid[rtsq_pkg::NUM_CELLS]),
    .in_ready    (stage_ready[rtsq_pkg::NUM_CELLS]),
    .in_lanes    (stage_lanes[rtsq_pkg::NUM_CELLS]),
    .step_length (step_length),
    .out_valid   (res_valid),
    .out_ready   (res_ready),
    .res         (res)
  );

  // The brightest channel always needs no ink, so one color is zero.
  a_one_color_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.cyan_steps == '0) || (res.magenta_steps == '0) ||
                  (res.yellow_steps == '0))
    else $error("no color channel at zero steps");

  // No channel exceeds the configured step count.
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.cyan_steps <= step_count) && (res.magenta_steps <= step_count) &&
                  (res.yellow_steps <= step_count) && (res.key_steps <= step_count))
    else $error("step count above configured maximum");

  // Key and cyan lengths agree with the step counts they come from.
  a_len_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.key_len == rtsq_pkg::LEN_W'(res.key_steps) *
                                  rtsq_pkg::LEN_W'(step_length)) &&
                  (res.cyan_len == rtsq_pkg::LEN_W'(res.cyan_steps) *
                                   rtsq_pkg::LEN_W'(step_length)))
    else $error("length does not match step count");

endmodule
